/* hdl/pws_pkg.sv */
// Shared constants, register codes and configuration type for the PID block.
`timescale 1ns / 1ps
package pws_pkg;

  localparam int PWS_ERROR_WIDTH = 32;
  localparam int PWS_ACCUM_WIDTH = 48;
  localparam int GAIN_WIDTH      = 24;
  localparam int BAND_WIDTH      = 31;
  localparam int TIMER_WIDTH     = 32;
  localparam int STEP_WIDTH      = 16;
  localparam int APB_ADDR_WIDTH  = 5;
  localparam int APB_DATA_WIDTH  = 32;
  localparam int REG_IDX_WIDTH   = 3;
  // Q8.16 gains: the product is scaled back by this many bits.
  localparam int FRAC_BITS       = 16;

  typedef enum logic [REG_IDX_WIDTH-1:0] {
    REG_GAIN_P         = 3'd0,
    REG_GAIN_I         = 3'd1,
    REG_GAIN_D         = 3'd2,
    REG_INTEGRATE_BAND = 3'd3,
    REG_SETTLE_BAND    = 3'd4,
    REG_SETTLE_LIMIT   = 3'd5,
    REG_RUN_TIMEOUT    = 3'd6
  } reg_idx_e;

  typedef struct packed {
    logic [GAIN_WIDTH-1:0]  gain_p;
    logic [GAIN_WIDTH-1:0]  gain_i;
    logic [GAIN_WIDTH-1:0]  gain_d;
    logic [BAND_WIDTH-1:0]  integrate_band;
    logic [BAND_WIDTH-1:0]  settle_band;
    logic [TIMER_WIDTH-1:0] settle_limit;
    logic [TIMER_WIDTH-1:0] run_timeout;
  } cfg_t;

endpackage

/* hdl/pws_in_if.sv */
// Input channel: one error sample and time step per beat.
`timescale 1ns / 1ps
interface pws_in_if #(
  parameter int ERROR_WIDTH = pws_pkg::PWS_ERROR_WIDTH
);
  logic                            valid;
  logic                            ready;
  logic [ERROR_WIDTH-1:0]          error_in;
  logic [pws_pkg::STEP_WIDTH-1:0]  time_step;

  modport source (output valid, output error_in, output time_step, input ready);
  modport sink   (input valid, input error_in, input time_step, output ready);
endinterface

/* hdl/pws_out_if.sv */
// Output channel: one drive value and settled flag per beat.
`timescale 1ns / 1ps
interface pws_out_if #(
  parameter int ERROR_WIDTH = pws_pkg::PWS_ERROR_WIDTH
);
  logic                   valid;
  logic                   ready;
  logic [ERROR_WIDTH-1:0] drive;
  logic                   settled;

  modport source (output valid, output drive, output settled, input ready);
  modport sink   (input valid, input drive, input settled, output ready);
endinterface

/* hdl/pws_cfg_regs.sv */
// APB-style configuration register file.
`timescale 1ns / 1ps
module pws_cfg_regs (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [pws_pkg::APB_ADDR_WIDTH-1:0] paddr,
  input  logic [pws_pkg::APB_DATA_WIDTH-1:0] pwdata,
  output logic [pws_pkg::APB_DATA_WIDTH-1:0] prdata,
  output logic                               pready,
  output pws_pkg::cfg_t                      cfg_o
);
  import pws_pkg::*;

  cfg_t     cfg_q, cfg_d;
  reg_idx_e idx;
  logic     wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign idx    = reg_idx_e'(paddr[APB_ADDR_WIDTH-1:2]);

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      case (idx)
        REG_GAIN_P:         cfg_d.gain_p         = pwdata[GAIN_WIDTH-1:0];
        REG_GAIN_I:         cfg_d.gain_i         = pwdata[GAIN_WIDTH-1:0];
        REG_GAIN_D:         cfg_d.gain_d         = pwdata[GAIN_WIDTH-1:0];
        REG_INTEGRATE_BAND: cfg_d.integrate_band = pwdata[BAND_WIDTH-1:0];
        REG_SETTLE_BAND:    cfg_d.settle_band    = pwdata[BAND_WIDTH-1:0];
        REG_SETTLE_LIMIT:   cfg_d.settle_limit   = pwdata[TIMER_WIDTH-1:0];
        REG_RUN_TIMEOUT:    cfg_d.run_timeout    = pwdata[TIMER_WIDTH-1:0];
        default:            cfg_d = cfg_q;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_GAIN_P:
        prdata = {{(APB_DATA_WIDTH-GAIN_WIDTH){1'b0}}, cfg_q.gain_p};
      REG_GAIN_I:
        prdata = {{(APB_DATA_WIDTH-GAIN_WIDTH){1'b0}}, cfg_q.gain_i};
      REG_GAIN_D:
        prdata = {{(APB_DATA_WIDTH-GAIN_WIDTH){1'b0}}, cfg_q.gain_d};
      REG_INTEGRATE_BAND:
        prdata = {{(APB_DATA_WIDTH-BAND_WIDTH){1'b0}}, cfg_q.integrate_band};
      REG_SETTLE_BAND:
        prdata = {{(APB_DATA_WIDTH-BAND_WIDTH){1'b0}}, cfg_q.settle_band};
      REG_SETTLE_LIMIT:   prdata = cfg_q.settle_limit;
      REG_RUN_TIMEOUT:    prdata = cfg_q.run_timeout;
      default:            prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

/* hdl/pws_front.sv */
// Input register, controller state update and the registered operands for the multipliers.
`timescale 1ns / 1ps
module pws_front #(
  parameter int ERROR_WIDTH = pws_pkg::PWS_ERROR_WIDTH,
  parameter int ACCUM_WIDTH = pws_pkg::PWS_ACCUM_WIDTH
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  pws_pkg::cfg_t                  cfg_i,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic [ERROR_WIDTH-1:0]         in_error_i,
  input  logic [pws_pkg::STEP_WIDTH-1:0] in_step_i,
  output logic                           s2_valid_o,
  input  logic                           s2_ready_i,
  output logic [ERROR_WIDTH-1:0]         s2_error_o,
  output logic [ERROR_WIDTH:0]           s2_diff_o,
  output logic [ACCUM_WIDTH-1:0]         s2_integ_o,
  output logic                           s2_done_o
);
  import pws_pkg::*;

  localparam int EW = ERROR_WIDTH;
  localparam int AW = ACCUM_WIDTH;
  localparam int IW = ((AW > EW) ? AW : EW) + 1;
  localparam int CW = 64;

  logic                   s1_valid_q, s1_valid_d;
  logic [EW-1:0]          s1_error_q;
  logic [STEP_WIDTH-1:0]  s1_step_q;
  logic                   s1_en, s2_en, s1_fire;

  logic [AW-1:0]          integ_q, integ_d;
  logic [EW-1:0]          last_q;
  logic [TIMER_WIDTH-1:0] settle_t_q, settle_t_d;
  logic [TIMER_WIDTH-1:0] run_t_q, run_t_d;

  logic                   s2_valid_q, s2_valid_d;
  logic [EW-1:0]          s2_error_q;
  logic [EW:0]            s2_diff_q, diff;
  logic [AW-1:0]          s2_integ_q;
  logic                   s2_done_q, done;

  logic [EW-1:0]          mag;
  logic                   e_pos, e_neg, l_pos, l_neg;
  logic                   in_int_band, in_settle_band;
  logic [IW-1:0]          acc_sum;
  logic                   acc_pos_ov, acc_neg_ov;
  logic [AW-1:0]          acc_sat;
  logic [TIMER_WIDTH:0]   settle_sum, run_sum;

  // Each stage loads when it is empty or its content moves on this cycle.
  assign s2_en      = !s2_valid_q || s2_ready_i;
  assign s1_en      = !s1_valid_q || s2_en;
  assign s1_fire    = s1_valid_q && s2_en;
  assign in_ready_o = s1_en;

  assign s1_valid_d = s1_en ? in_valid_i : s1_valid_q;
  assign s2_valid_d = s2_en ? s1_valid_q : s2_valid_q;

  assign e_neg = s1_error_q[EW-1];
  assign e_pos = !s1_error_q[EW-1] && (|s1_error_q);
  assign l_neg = last_q[EW-1];
  assign l_pos = !last_q[EW-1] && (|last_q);
  assign mag   = e_neg ? (~s1_error_q + 1'b1) : s1_error_q;

  assign in_int_band    = {{(CW-EW){1'b0}}, mag} <
                          {{(CW-BAND_WIDTH){1'b0}}, cfg_i.integrate_band};
  assign in_settle_band = {{(CW-EW){1'b0}}, mag} <
                          {{(CW-BAND_WIDTH){1'b0}}, cfg_i.settle_band};

  // Saturating accumulate; the sum overflows when its top bits disagree.
  assign acc_sum    = {{(IW-AW){integ_q[AW-1]}}, integ_q} +
                      {{(IW-EW){s1_error_q[EW-1]}}, s1_error_q};
  assign acc_pos_ov = !acc_sum[IW-1] && !(&(~acc_sum[IW-2:AW-1]));
  assign acc_neg_ov = acc_sum[IW-1] && !(&acc_sum[IW-2:AW-1]);

  always_comb begin
    if (acc_pos_ov) begin
      acc_sat = {1'b0, {(AW-1){1'b1}}};
    end else if (acc_neg_ov) begin
      acc_sat = {1'b1, {(AW-1){1'b0}}};
    end else begin
      acc_sat = acc_sum[AW-1:0];
    end
    integ_d = in_int_band ? acc_sat : integ_q;
    // A strict sign change against the previous sample clears the integral.
    if ((e_pos && l_neg) || (e_neg && l_pos)) begin
      integ_d = '0;
    end
  end

  assign diff = {s1_error_q[EW-1], s1_error_q} - {last_q[EW-1], last_q};

  assign settle_sum = {1'b0, settle_t_q} + {{(TIMER_WIDTH+1-STEP_WIDTH){1'b0}}, s1_step_q};
  assign run_sum    = {1'b0, run_t_q} + {{(TIMER_WIDTH+1-STEP_WIDTH){1'b0}}, s1_step_q};

  always_comb begin
    if (!in_settle_band) begin
      settle_t_d = '0;
    end else if (settle_sum[TIMER_WIDTH]) begin
      settle_t_d = '1;
    end else begin
      settle_t_d = settle_sum[TIMER_WIDTH-1:0];
    end
    run_t_d = run_sum[TIMER_WIDTH] ? '1 : run_sum[TIMER_WIDTH-1:0];
  end

  assign done = ((|cfg_i.run_timeout) && (run_t_d > cfg_i.run_timeout)) ||
                (settle_t_d > cfg_i.settle_limit);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
      integ_q    <= '0;
      last_q     <= '0;
      settle_t_q <= '0;
      run_t_q    <= '0;
    end else begin
      s1_valid_q <= s1_valid_d;
      s2_valid_q <= s2_valid_d;
      if (s1_fire) begin
        integ_q    <= integ_d;
        last_q     <= s1_error_q;
        settle_t_q <= settle_t_d;
        run_t_q    <= run_t_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_en && in_valid_i) begin
      s1_error_q <= in_error_i;
      s1_step_q  <= in_step_i;
    end
    if (s1_fire) begin
      s2_error_q <= s1_error_q;
      s2_diff_q  <= diff;
      s2_integ_q <= integ_d;
      s2_done_q  <= done;
    end
  end

  assign s2_valid_o = s2_valid_q;
  assign s2_error_o = s2_error_q;
  assign s2_diff_o  = s2_diff_q;
  assign s2_integ_o = s2_integ_q;
  assign s2_done_o  = s2_done_q;

endmodule

/* hdl/pws_mult.sv */
// Gain times signed operand in two registered half products, recombined and scaled down.
`timescale 1ns / 1ps
module pws_mult #(
  parameter int OP_WIDTH = pws_pkg::PWS_ERROR_WIDTH
) (
  input  logic                           clk_i,
  input  logic                           en_i,
  input  logic [pws_pkg::GAIN_WIDTH-1:0] gain_i,
  input  logic [OP_WIDTH-1:0]            op_i,
  output logic [OP_WIDTH+8:0]            term_o
);
  import pws_pkg::*;

  localparam int GW   = GAIN_WIDTH;
  localparam int HALF = OP_WIDTH / 2;
  localparam int HW   = OP_WIDTH - HALF;
  localparam int HPW  = HW + GW + 1;
  localparam int LPW  = HALF + GW;
  localparam int PW   = OP_WIDTH + GW + 1;

  logic [HW-1:0]   op_hi;
  logic [HALF-1:0] op_lo;
  logic [HPW-1:0]  hi_prod_d, hi_prod_q;
  logic [LPW-1:0]  lo_prod_d, lo_prod_q;
  logic [PW-1:0]   full;

  assign op_hi = op_i[OP_WIDTH-1:HALF];
  assign op_lo = op_i[HALF-1:0];

  // Upper half is signed: sign-extend it and keep the low bits of the product.
  assign hi_prod_d = {{(GW+1){op_hi[HW-1]}}, op_hi} * {{(HW+1){1'b0}}, gain_i};
  assign lo_prod_d = {{GW{1'b0}}, op_lo} * {{HALF{1'b0}}, gain_i};

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      hi_prod_q <= hi_prod_d;
      lo_prod_q <= lo_prod_d;
    end
  end

  assign full = {hi_prod_q[HPW-1:0], {HALF{1'b0}}} +
                {{(PW-LPW){1'b0}}, lo_prod_q};

  // Dropping the fraction bits of a two's complement value rounds toward minus infinity.
  assign term_o = full[PW-1:FRAC_BITS];

endmodule

/* hdl/pws_back.sv */
// Product stage and the summing, saturating output register.
`timescale 1ns / 1ps
module pws_back #(
  parameter int ERROR_WIDTH = pws_pkg::PWS_ERROR_WIDTH,
  parameter int ACCUM_WIDTH = pws_pkg::PWS_ACCUM_WIDTH
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  pws_pkg::cfg_t          cfg_i,
  input  logic                   s2_valid_i,
  output logic                   s2_ready_o,
  input  logic [ERROR_WIDTH-1:0] s2_error_i,
  input  logic [ERROR_WIDTH:0]   s2_diff_i,
  input  logic [ACCUM_WIDTH-1:0] s2_integ_i,
  input  logic                   s2_done_i,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output logic [ERROR_WIDTH-1:0] out_drive_o,
  output logic                   out_settled_o
);
  import pws_pkg::*;

  localparam int EW = ERROR_WIDTH;
  localparam int AW = ACCUM_WIDTH;
  localparam int TP = EW + 9;
  localparam int TD = EW + 10;
  localparam int TI = AW + 9;
  localparam int SW = ((TD > TI) ? TD : TI) + 2;

  logic          s3_valid_q, s3_valid_d, s3_done_q;
  logic          s4_valid_q, s4_valid_d;
  logic [EW-1:0] s4_drive_q, drive_d;
  logic          s4_settled_q;
  logic          s3_en, s4_en;

  logic [TP-1:0] term_p;
  logic [TD-1:0] term_d;
  logic [TI-1:0] term_i;
  logic [SW-1:0] sum;
  logic          pos_ov, neg_ov;

  assign s4_en      = !s4_valid_q || out_ready_i;
  assign s3_en      = !s3_valid_q || s4_en;
  assign s2_ready_o = s3_en;
  assign s3_valid_d = s3_en ? s2_valid_i : s3_valid_q;
  assign s4_valid_d = s4_en ? s3_valid_q : s4_valid_q;

  pws_mult #(.OP_WIDTH(EW)) u_mult_p (
    .clk_i  (clk_i),
    .en_i   (s3_en),
    .gain_i (cfg_i.gain_p),
    .op_i   (s2_error_i),
    .term_o (term_p)
  );

  pws_mult #(.OP_WIDTH(AW)) u_mult_i (
    .clk_i  (clk_i),
    .en_i   (s3_en),
    .gain_i (cfg_i.gain_i),
    .op_i   (s2_integ_i),
    .term_o (term_i)
  );

  pws_mult #(.OP_WIDTH(EW + 1)) u_mult_d (
    .clk_i  (clk_i),
    .en_i   (s3_en),
    .gain_i (cfg_i.gain_d),
    .op_i   (s2_diff_i),
    .term_o (term_d)
  );

  assign sum = {{(SW-TP){term_p[TP-1]}}, term_p} +
               {{(SW-TI){term_i[TI-1]}}, term_i} +
               {{(SW-TD){term_d[TD-1]}}, term_d};

  assign pos_ov = !sum[SW-1] && !(&(~sum[SW-2:EW-1]));
  assign neg_ov = sum[SW-1] && !(&sum[SW-2:EW-1]);

  always_comb begin
    if (pos_ov) begin
      drive_d = {1'b0, {(EW-1){1'b1}}};
    end else if (neg_ov) begin
      drive_d = {1'b1, {(EW-1){1'b0}}};
    end else begin
      drive_d = sum[EW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s3_valid_q <= 1'b0;
      s4_valid_q <= 1'b0;
    end else begin
      s3_valid_q <= s3_valid_d;
      s4_valid_q <= s4_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s3_en) begin
      s3_done_q <= s2_done_i;
    end
    if (s4_en) begin
      s4_drive_q   <= drive_d;
      s4_settled_q <= s3_done_q;
    end
  end

  assign out_valid_o   = s4_valid_q;
  assign out_drive_o   = s4_drive_q;
  assign out_settled_o = s4_settled_q;

endmodule

/* hdl/pid_with_settle_detect.sv */
// Top level of the PID controller with integration band and settle detection.
//
//   channel   direction  payload                      handshake
//   sample_i  in         error_in, time_step          valid / ready
//   result_o  out        drive, settled               valid / ready
//   apb       in/out     7 registers at 4*index       psel, penable, pwrite, pready
//
// One sample is accepted per cycle while the output is not stalled; it passes from the
// input register through the operand and half-product registers to the output register.
// The integral, last error and timers close their loop around the input register, so
// back-to-back samples never wait on it. The multiplies run as registered half products.
// Each stage refills while the next one stalls, so input ready drops only once all four
// registers hold beats. Reset clears the state, the registers and all valid flags.
`timescale 1ns / 1ps
module pid_with_settle_detect #(
  parameter int ERROR_WIDTH = pws_pkg::PWS_ERROR_WIDTH,
  parameter int ACCUM_WIDTH = pws_pkg::PWS_ACCUM_WIDTH
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  pws_in_if.sink                             sample_i,
  pws_out_if.source                          result_o,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [pws_pkg::APB_ADDR_WIDTH-1:0] paddr,
  input  logic [pws_pkg::APB_DATA_WIDTH-1:0] pwdata,
  output logic [pws_pkg::APB_DATA_WIDTH-1:0] prdata,
  output logic                               pready
);
  import pws_pkg::*;

  cfg_t                   cfg;
  logic                   s2_valid, s2_ready, s2_done;
  logic [ERROR_WIDTH-1:0] s2_error;
  logic [ERROR_WIDTH:0]   s2_diff;
  logic [ACCUM_WIDTH-1:0] s2_integ;

  pws_cfg_regs u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  pws_front #(
    .ERROR_WIDTH (ERROR_WIDTH),
    .ACCUM_WIDTH (ACCUM_WIDTH)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg),
    .in_valid_i (sample_i.valid),
    .in_ready_o (sample_i.ready),
    .in_error_i (sample_i.error_in),
    .in_step_i  (sample_i.time_step),
    .s2_valid_o (s2_valid),
    .s2_ready_i (s2_ready),
    .s2_error_o (s2_error),
    .s2_diff_o  (s2_diff),
    .s2_integ_o (s2_integ),
    .s2_done_o  (s2_done)
  );

  pws_back #(
    .ERROR_WIDTH (ERROR_WIDTH),
    .ACCUM_WIDTH (ACCUM_WIDTH)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg),
    .s2_valid_i    (s2_valid),
    .s2_ready_o    (s2_ready),
    .s2_error_i    (s2_error),
    .s2_diff_i     (s2_diff),
    .s2_integ_i    (s2_integ),
    .s2_done_i     (s2_done),
    .out_valid_o   (result_o.valid),
    .out_ready_i   (result_o.ready),
    .out_drive_o   (result_o.drive),
    .out_settled_o (result_o.settled)
  );

endmodule

/* sim/pid_with_settle_detect_tb.sv */
// Self-checking testbench for the PID controller with settle detection.
`timescale 1ns / 1ps
module pid_with_settle_detect_tb;
  import pws_pkg::*;

  typedef struct packed {
    logic [PWS_ERROR_WIDTH-1:0] drive;
    logic                       settled;
  } pid_result_t;

  // Mirror of the controller: its own registers, integral, last error and timers.
  class pid_mirror;
    cfg_t              cfg;
    longint            integ_sum;
    longint            last_err;
    longint unsigned   settle_ticks;
    longint unsigned   run_ticks;
    pid_result_t       owed_results[$];
    int                errors;
    int                compared;

    function new();
      cfg          = '0;
      integ_sum    = 0;
      last_err     = 0;
      settle_ticks = 0;
      run_ticks    = 0;
      errors       = 0;
      compared     = 0;
    endfunction

    task report_mismatch(string msg);
      errors++;
      if (errors <= 100) begin
        $display("mismatch at %0t: %s", $realtime, msg);
      end
    endtask

    function void write_reg(reg_idx_e idx, logic [31:0] v);
      case (idx)
        REG_GAIN_P:         cfg.gain_p = v[GAIN_WIDTH-1:0];
        REG_GAIN_I:         cfg.gain_i = v[GAIN_WIDTH-1:0];
        REG_GAIN_D:         cfg.gain_d = v[GAIN_WIDTH-1:0];
        REG_INTEGRATE_BAND: cfg.integrate_band = v[BAND_WIDTH-1:0];
        REG_SETTLE_BAND:    cfg.settle_band = v[BAND_WIDTH-1:0];
        REG_SETTLE_LIMIT:   cfg.settle_limit = v;
        REG_RUN_TIMEOUT:    cfg.run_timeout = v;
        default: ;
      endcase
    endfunction

    function logic [31:0] reg_value(reg_idx_e idx);
      case (idx)
        REG_GAIN_P:         return 32'(cfg.gain_p);
        REG_GAIN_I:         return 32'(cfg.gain_i);
        REG_GAIN_D:         return 32'(cfg.gain_d);
        REG_INTEGRATE_BAND: return 32'(cfg.integrate_band);
        REG_SETTLE_BAND:    return 32'(cfg.settle_band);
        REG_SETTLE_LIMIT:   return cfg.settle_limit;
        REG_RUN_TIMEOUT:    return cfg.run_timeout;
        default:            return '0;
      endcase
    endfunction

    // floor(gain * x / 2^16). A term stays below 2^56 in magnitude at these widths,
    // so the 80-bit result cannot overflow.
    function logic signed [79:0] q16_term(logic [GAIN_WIDTH-1:0] gain, longint x);
      logic signed [79:0] g_wide;
      logic signed [79:0] x_wide;
      g_wide = {56'd0, gain};
      x_wide = x;
      return (g_wide * x_wide) >>> FRAC_BITS;
    endfunction

    function longint unsigned add_ticks(longint unsigned t, logic [STEP_WIDTH-1:0] d);
      longint unsigned s;
      s = t + d;
      return (s > 64'hFFFF_FFFF) ? 64'hFFFF_FFFF : s;
    endfunction

    function void note_sample(logic [PWS_ERROR_WIDTH-1:0] err_bits,
                              logic [STEP_WIDTH-1:0] step);
      longint             e;
      longint             mag;
      longint             acc_max;
      longint             acc_min;
      logic signed [79:0] total;
      pid_result_t        res;
      e       = longint'($signed(err_bits));
      mag     = (e < 0) ? -e : e;
      acc_max = (longint'(1) <<< (PWS_ACCUM_WIDTH - 1)) - 1;
      acc_min = -acc_max - 1;
      if (mag < longint'(cfg.integrate_band)) begin
        if (e > 0 && integ_sum > acc_max - e) begin
          integ_sum = acc_max;
        end else if (e < 0 && integ_sum < acc_min - e) begin
          integ_sum = acc_min;
        end else begin
          integ_sum += e;
        end
      end
      // A zero error on either side is not a sign flip.
      if ((e > 0 && last_err < 0) || (e < 0 && last_err > 0)) begin
        integ_sum = 0;
      end
      total = q16_term(cfg.gain_p, e) + q16_term(cfg.gain_i, integ_sum)
            + q16_term(cfg.gain_d, e - last_err);
      if (total > 80'sh7FFF_FFFF) begin
        total = 80'sh7FFF_FFFF;
      end
      if (total < -80'sh8000_0000) begin
        total = -80'sh8000_0000;
      end
      last_err = e;
      if (mag < longint'(cfg.settle_band)) begin
        settle_ticks = add_ticks(settle_ticks, step);
      end else begin
        settle_ticks = 0;
      end
      run_ticks   = add_ticks(run_ticks, step);
      res.drive   = total[PWS_ERROR_WIDTH-1:0];
      res.settled = (cfg.run_timeout != 0 && run_ticks > cfg.run_timeout) ||
                    (settle_ticks > cfg.settle_limit);
      owed_results.push_back(res);
    endfunction

    task check_result(logic [PWS_ERROR_WIDTH-1:0] drive, logic settled);
      pid_result_t want;
      if (owed_results.size() == 0) begin
        report_mismatch($sformatf("unexpected result drive=%h settled=%b", drive, settled));
        return;
      end
      want = owed_results.pop_front();
      compared++;
      if (drive !== want.drive) begin
        report_mismatch($sformatf("result %0d drive %h, expected %h",
                                  compared, drive, want.drive));
      end
      if (settled !== want.settled) begin
        report_mismatch($sformatf("result %0d settled %b, expected %b",
                                  compared, settled, want.settled));
      end
    endtask
  endclass

  logic                      clk_i = 1'b0;
  logic                      rst_ni = 1'b0;
  logic                      psel = 1'b0;
  logic                      penable = 1'b0;
  logic                      pwrite = 1'b0;
  logic [APB_ADDR_WIDTH-1:0] paddr = '0;
  logic [APB_DATA_WIDTH-1:0] pwdata = '0;
  logic [APB_DATA_WIDTH-1:0] prdata;
  logic                      pready;

  pws_in_if  smp_if ();
  pws_out_if res_if ();

  pid_with_settle_detect dut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .sample_i (smp_if),
    .result_o (res_if),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  pid_mirror mirror = new();
  int        idle_mode = 0;
  int        samples_sent = 0;
  int        settings_used = 0;

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // 0: no idling, 1: a random idle gap, possibly none, before every beat, 2: occasional idling.
  function automatic int draw_gap();
    case (idle_mode)
      0:       return 0;
      1:       return $urandom_range(0, 16);
      default: return ($urandom_range(0, 3) == 0) ? $urandom_range(1, 16) : 0;
    endcase
  endfunction

  task automatic push_sample(logic [PWS_ERROR_WIDTH-1:0] err, logic [STEP_WIDTH-1:0] step);
    int gap;
    gap = draw_gap();
    repeat (gap) begin
      @(negedge clk_i);
      smp_if.valid = 1'b0;
    end
    @(negedge clk_i);
    smp_if.valid     = 1'b1;
    smp_if.error_in  = err;
    smp_if.time_step = step;
    do @(posedge clk_i); while (!smp_if.ready);
    mirror.note_sample(err, step);
    samples_sent++;
  endtask

  task automatic hold_until_drained();
    @(negedge clk_i);
    smp_if.valid = 1'b0;
    while (mirror.owed_results.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic apb_access(logic wr, reg_idx_e idx, logic [31:0] data,
                            output logic [31:0] rdata);
    @(negedge clk_i);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = wr;
    paddr   = {idx, 2'b00};
    pwdata  = data;
    @(negedge clk_i);
    penable = 1'b1;
    do @(posedge clk_i); while (!pready);
    rdata = prdata;
    @(negedge clk_i);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
  endtask

  task automatic readback(reg_idx_e idx);
    logic [31:0] got;
    apb_access(1'b0, idx, '0, got);
    if (got !== mirror.reg_value(idx)) begin
      mirror.report_mismatch($sformatf("register %s reads %h, expected %h",
                                       idx.name(), got, mirror.reg_value(idx)));
    end
  endtask

  task automatic program_reg(reg_idx_e idx, logic [31:0] value);
    logic [31:0] ignored;
    apb_access(1'b1, idx, value, ignored);
    mirror.write_reg(idx, value);
    readback(idx);
  endtask

  task automatic program_all(logic [31:0] gp, logic [31:0] gi, logic [31:0] gd,
                             logic [31:0] ib, logic [31:0] sband, logic [31:0] sl,
                             logic [31:0] rt);
    program_reg(REG_GAIN_P, gp);
    program_reg(REG_GAIN_I, gi);
    program_reg(REG_GAIN_D, gd);
    program_reg(REG_INTEGRATE_BAND, ib);
    program_reg(REG_SETTLE_BAND, sband);
    program_reg(REG_SETTLE_LIMIT, sl);
    program_reg(REG_RUN_TIMEOUT, rt);
    settings_used++;
  endtask

  // Random gain and band picks leave junk in the bits above each register's width.
  function automatic logic [31:0] pick_gain();
    logic [31:0] w;
    w = $urandom;
    case ($urandom_range(0, 4))
      0:       w[GAIN_WIDTH-1:0] = '0;
      1:       w[GAIN_WIDTH-1:0] = '1;
      2:       w[GAIN_WIDTH-1:0] = 24'h01_0000;
      3:       w[GAIN_WIDTH-1:0] = 24'($urandom_range(0, 32'h3_FFFF));
      default: ;
    endcase
    return w;
  endfunction

  function automatic logic [31:0] pick_band();
    logic [31:0] w;
    w = $urandom;
    case ($urandom_range(0, 4))
      0:       w[BAND_WIDTH-1:0] = '0;
      1:       w[BAND_WIDTH-1:0] = '1;
      2:       w[BAND_WIDTH-1:0] = 31'($urandom_range(0, 32'h0008_0000));
      3:       w[BAND_WIDTH-1:0] = 31'($urandom_range(0, 32'h0100_0000));
      default: ;
    endcase
    return w;
  endfunction

  function automatic logic [31:0] pick_limit();
    case ($urandom_range(0, 3))
      0:       return '0;
      1:       return '1;
      2:       return $urandom_range(0, 3000);
      default: return $urandom;
    endcase
  endfunction

  // Timeouts just past the current run time make the flag change within a phase.
  function automatic logic [31:0] pick_timeout();
    case ($urandom_range(0, 4))
      0:       return '0;
      1:       return '1;
      2, 3:    return 32'(mirror.run_ticks + $urandom_range(0, 40000));
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [31:0] pick_error();
    logic [31:0] mag;
    case ($urandom_range(0, 9))
      0: mag = $urandom;
      1: begin
        case ($urandom_range(0, 4))
          0:       mag = 32'h7FFF_FFFF;
          1:       mag = 32'h8000_0000;
          2:       mag = '0;
          3:       mag = 32'd1;
          default: mag = '1;
        endcase
      end
      2, 3:    mag = $urandom_range(0, 32'h0003_FFFF);
      4:       mag = 32'(mirror.cfg.integrate_band) + $urandom_range(0, 4) - 2;
      5:       mag = 32'(mirror.cfg.settle_band) + $urandom_range(0, 4) - 2;
      default: mag = $urandom_range(0, 32'h00FF_FFFF);
    endcase
    return $urandom_range(0, 1) ? -mag : mag;
  endfunction

  function automatic logic [STEP_WIDTH-1:0] pick_step();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      2:       return 16'($urandom);
      default: return 16'($urandom_range(0, 300));
    endcase
  endfunction

  initial begin : result_sink
    int gap;
    res_if.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      gap = draw_gap();
      repeat (gap) begin
        @(negedge clk_i);
        res_if.ready = 1'b0;
      end
      @(negedge clk_i);
      res_if.ready = 1'b1;
      do @(posedge clk_i); while (!res_if.valid);
      mirror.check_result(res_if.drive, res_if.settled);
    end
  end

  initial begin : stimulus
    logic [31:0] err;
    int          pattern;
    logic        run_sign;
    reg_idx_e    idx;
    smp_if.valid     = 1'b0;
    smp_if.error_in  = '0;
    smp_if.time_step = '0;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Every register must read back zero out of reset.
    idx = idx.first();
    do begin
      readback(idx);
      idx = idx.next();
    end while (idx != idx.first());

    // Directed: unit-ish gains, 5.0 integrate band, 1.0 settle band, no timeout.
    idle_mode = 2;
    program_all(32'h0001_0000, 32'h0000_4000, 32'h0000_8000, 32'h0005_0000,
                32'h0001_0000, 32'd20, 32'd0);
    push_sample(32'h0000_0000, 16'd0);
    push_sample(32'h7FFF_FFFF, 16'hFFFF);
    push_sample(32'h8000_0000, 16'd1);    // flips against a positive error
    push_sample(32'hFFFF_FFFF, 16'd2);
    push_sample(32'h0000_0001, 16'd3);    // flips against a negative error
    push_sample(32'h0005_0000, 16'd5);    // exactly on the band, not integrated
    push_sample(32'h0004_FFFF, 16'd5);
    push_sample(32'hFFFB_0001, 16'd5);
    push_sample(32'h0000_0000, 16'd7);    // zero does not count as a flip
    push_sample(32'hFFFF_0000, 16'd0);
    push_sample(32'h0000_8000, 16'd10);
    push_sample(32'h0000_8000, 16'd10);
    push_sample(32'h0000_8000, 16'd10);   // settle time passes the limit
    push_sample(32'h0001_0000, 16'd1);    // on the settle band, timer clears
    push_sample(32'h0000_FFFF, 16'd21);
    hold_until_drained();

    // Directed: top gains with junk above them, bands written as junk only, short timeout.
    program_all(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h8000_0000,
                32'h8000_0000, 32'd0, 32'd5);
    push_sample(32'h7FFF_FFFF, 16'd3);
    push_sample(32'h8000_0000, 16'd3);
    push_sample(32'h7FFF_FFFF, 16'd0);
    push_sample(32'h8000_0000, 16'hFFFF);

    for (int phase = 0; phase < 6; phase++) begin
      hold_until_drained();
      if (phase == 0) begin
        program_all('1, '1, '1, 32'h7FFF_FFFF, 32'h7FFF_FFFF, '1, '1);
      end else begin
        program_all(pick_gain(), pick_gain(), pick_gain(), pick_band(), pick_band(),
                    pick_limit(), pick_timeout());
      end
      pattern  = 0;
      run_sign = 1'b0;
      for (int i = 0; i < 325; i++) begin
        if (i % 50 == 0) begin
          idle_mode = $urandom_range(0, 2);
        end
        if (i % 8 == 0) begin
          pattern  = $urandom_range(0, 3);
          run_sign = 1'($urandom_range(0, 1));
        end
        if (i == 160) begin
          hold_until_drained();
        end
        err = pick_error();
        case (pattern)
          1: if (err[31] != run_sign) err = -err;
          2: begin
            if (err[31] != run_sign) err = -err;
            run_sign = !run_sign;
          end
          3: if (i % 2 == 1) err = '0;
          default: ;
        endcase
        push_sample(err, pick_step());
      end
    end

    // Back-to-back runs of wide errors with the longest steps push the drive to both rails.
    hold_until_drained();
    idle_mode = 0;
    program_all(32'h0001_0000, 32'h0000_0100, 32'h0001_0000, 32'h7FFF_FFFF,
                32'h7FFF_FFFF, 32'hFFFF_FFFE, 32'hFFFF_FFFF);
    repeat (16) push_sample(32'h7FFF_FFFE, 16'hFFFF);
    repeat (16) push_sample(32'h8000_0002, 16'hFFFF);
    push_sample(32'h7FFF_FFFF, 16'hFFFF);
    push_sample(32'h0000_0000, 16'd1);
    hold_until_drained();
    idle_mode = 2;
    program_reg(REG_RUN_TIMEOUT, 32'hFFFF_FFFE);
    push_sample(32'h7FFF_FFFF, 16'd0);
    push_sample(32'h8000_0000, 16'd0);

    hold_until_drained();
    repeat (8) @(posedge clk_i);
    $display("Sent %0d samples under %0d register settings; %0d results compared.",
             samples_sent, settings_used, mirror.compared);
    $display("Covered sign flips, band edges, settle and timeout flags, and saturation.");
    if (mirror.errors == 0) begin
      $display("pid_with_settle_detect test passed");
    end else begin
      $display("pid_with_settle_detect test failed");
    end
    $finish;
  end

  initial begin : watchdog
    #6_000_000;
    $display("pid_with_settle_detect test failed");
    $finish;
  end

endmodule
